@@ sv/heading_reference_offset_unit_macros.svh @@
// Assertion macros for the heading reference offset unit.
// Needs clk and rst in the scope of each use.
`ifndef HEADING_REFERENCE_OFFSET_UNIT_MACROS_SVH
`define HEADING_REFERENCE_OFFSET_UNIT_MACROS_SVH

// same-cycle implication
`define HRO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/hro_pkg.sv @@
// Package for the heading reference offset unit: widths, heading constants,
// command codes, configuration register indexes. No dependencies.
package hro_pkg;

  localparam int MAX_SAMPLES = 1023;

  localparam int HEAD_W     = 13;
  localparam int OUT_W      = 14;
  localparam int CNT_W      = 10;
  localparam int THR_W      = 13;
  localparam int SUM_W      = 23;
  localparam int SQS_W      = 36;
  localparam int PROD_W     = 46;
  localparam int MUL_W      = 24;
  localparam int SPLIT_W    = 18;
  localparam int DIFF_W     = HEAD_W + 2;
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [HEAD_W-1:0] TURN      = HEAD_W'(5760);
  localparam logic [HEAD_W-1:0] HALF_TURN = HEAD_W'(2880);

  localparam logic CMD_REFERENCE = 1'b0;
  localparam logic CMD_MEASURE   = 1'b1;

  localparam logic [CNT_W-1:0] REF_LENGTH_RESET    = CNT_W'(300);
  localparam logic [THR_W-1:0] STD_THRESHOLD_RESET = THR_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_REF_LENGTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STD_THRESHOLD = CFG_IDX_W'(1);

endpackage

@@ sv/hro_channels.sv @@
// Handshake channels of the heading reference offset unit.
// Depends on hro_pkg.
interface hro_sample_if;
  import hro_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [HEAD_W-1:0] heading;

  modport source (output valid, output cmd, output heading, input ready);
  modport sink (input valid, input cmd, input heading, output ready);
endinterface

interface hro_result_if;
  import hro_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] heading_out;
  logic                    offset_applied;
  logic                    reference_done;
  logic                    reference_stable;

  modport source (output valid, output heading_out, output offset_applied,
                  output reference_done, output reference_stable, input ready);
  modport sink (input valid, input heading_out, input offset_applied,
                input reference_done, input reference_stable, output ready);
endinterface

@@ sv/hro_mul.sv @@
// Shared unsigned multiplier with a registered product.
// Depends on hro_pkg.
module hro_mul (
  input  logic                          clk,
  input  logic [hro_pkg::MUL_W-1:0]     a,
  input  logic [hro_pkg::MUL_W-1:0]     b,
  output logic [2*hro_pkg::MUL_W-1:0]   p
);
  import hro_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

@@ sv/hro_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on hro_pkg.
module hro_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hro_pkg::SUM_W-1:0] dividend,
  input  logic [hro_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [hro_pkg::SUM_W-1:0] quotient
);
  import hro_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CNT_W-1:0]     rem;
  logic [SUM_W-1:0]     dvd;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_sub;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem, dvd[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    fits    = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
        rem  <= '0;
        dvd  <= dividend;
      end else if (busy) begin
        rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dvd <= {dvd[SUM_W-2:0], fits};
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;
endmodule

@@ sv/heading_reference_offset_unit.sv @@
// Heading reference offset unit. One item at a time: ready is high only while
// idle. A measure sample goes through S_START and S_WRITE to the result
// register, a reference sample that does not complete a reference through
// S_START, S_ACC and S_WRITE. The completing sample runs six passes through
// the shared 24x24 multiplier, a 46-bit stability compare and, when stable,
// the 23-step serial divider for the rounded mean. Ready returns as the result
// register loads. Results wait in an output register; the next sample is taken
// while one waits.
// Depends on hro_pkg, hro_channels, hro_mul, hro_div and the macro header.
`include "heading_reference_offset_unit_macros.svh"

module heading_reference_offset_unit (
  input  logic                          clk,
  input  logic                          rst,
  hro_sample_if.sink                    sample,
  hro_result_if.source                  result,
  input  logic                          cfg_we,
  input  logic [hro_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hro_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hro_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ACC, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
    S_CMP, S_DIV, S_WRITE
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  ref_length;
  logic [THR_W-1:0]  std_threshold;
  logic [CNT_W-1:0]  sample_total;
  logic [SUM_W-1:0]  heading_sum;
  logic [SQS_W-1:0]  heading_square_sum;
  logic [HEAD_W-1:0] last_sample;
  logic [HEAD_W-1:0] reference_offset;
  logic              offset_valid;

  logic              cmd;
  logic [HEAD_W-1:0] head;
  logic [PROD_W-1:0] sum_sq;
  logic [PROD_W-1:0] lim_sq;
  logic [PROD_W-1:0] acc;

  logic signed [OUT_W-1:0] st_heading;
  logic                    st_done;
  logic                    st_stable;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] mul_p;

  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_q;
  logic [SUM_W-1:0] div_dvd;

  logic [HEAD_W-1:0]        head_fold;
  logic [CNT_W-1:0]         target;
  logic [CNT_W-1:0]         total_inc;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_wrap;
  logic                     stable;

  hro_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  hro_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (sample_total),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    head_fold = (sample.heading >= TURN) ? sample.heading - TURN : sample.heading;

    target = ref_length;
    if (ref_length == '0) begin
      target = CNT_W'(1);
    end
    if (32'(ref_length) > 32'(MAX_SAMPLES)) begin
      target = CNT_W'(MAX_SAMPLES);
    end
    total_inc = sample_total + CNT_W'(1);

    diff = $signed({2'b00, head}) - $signed({2'b00, reference_offset});
    diff_wrap = diff;
    if (diff > $signed({2'b00, HALF_TURN})) begin
      diff_wrap = diff - $signed({2'b00, TURN});
    end else if (diff < -$signed({2'b00, HALF_TURN})) begin
      diff_wrap = diff + $signed({2'b00, TURN});
    end

    stable    = (acc - sum_sq) < lim_sq;
    div_start = (state == S_CMP) && stable;
    div_dvd   = heading_sum + SUM_W'(sample_total >> 1);

    mul_a = '0;
    mul_b = '0;
    case (state)
      S_START: begin
        mul_a = MUL_W'(head);
        mul_b = MUL_W'(head);
      end
      S_M1: begin
        mul_a = MUL_W'(heading_sum);
        mul_b = MUL_W'(heading_sum);
      end
      S_M2: begin
        mul_a = MUL_W'(std_threshold);
        mul_b = MUL_W'(sample_total);
      end
      S_M3: begin
        mul_a = mul_p[MUL_W-1:0];
        mul_b = mul_p[MUL_W-1:0];
      end
      S_M4: begin
        mul_a = MUL_W'(sample_total);
        mul_b = MUL_W'(heading_square_sum[SPLIT_W-1:0]);
      end
      S_M5: begin
        mul_a = MUL_W'(sample_total);
        mul_b = MUL_W'(heading_square_sum[SQS_W-1:SPLIT_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sample.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      ref_length         <= REF_LENGTH_RESET;
      std_threshold      <= STD_THRESHOLD_RESET;
      sample_total       <= '0;
      heading_sum        <= '0;
      heading_square_sum <= '0;
      last_sample        <= '0;
      reference_offset   <= '0;
      offset_valid       <= 1'b0;
      result.valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REF_LENGTH:    ref_length    <= cfg_data[CNT_W-1:0];
          REG_STD_THRESHOLD: std_threshold <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end

      if (state == S_WRITE && (!result.valid || result.ready)) begin
        result.valid            <= 1'b1;
        result.heading_out      <= st_heading;
        result.offset_applied   <= offset_valid;
        result.reference_done   <= st_done;
        result.reference_stable <= st_stable;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            cmd   <= sample.cmd;
            head  <= head_fold;
            state <= S_START;
          end
        end
        S_START: begin
          st_done   <= 1'b0;
          st_stable <= 1'b0;
          if (cmd == CMD_MEASURE) begin
            st_heading <= offset_valid ? diff_wrap[OUT_W-1:0] : $signed(OUT_W'(head));
            state      <= S_WRITE;
          end else begin
            st_heading <= '0;
            state      <= S_ACC;
          end
        end
        S_ACC: begin
          sample_total       <= total_inc;
          heading_sum        <= heading_sum + SUM_W'(head);
          heading_square_sum <= heading_square_sum + SQS_W'(mul_p);
          last_sample        <= head;
          state              <= (total_inc >= target) ? S_M1 : S_WRITE;
        end
        S_M1: state <= S_M2;
        S_M2: begin
          sum_sq <= mul_p[PROD_W-1:0];
          state  <= S_M3;
        end
        S_M3: state <= S_M4;
        S_M4: begin
          lim_sq <= mul_p[PROD_W-1:0];
          state  <= S_M5;
        end
        S_M5: begin
          acc   <= mul_p[PROD_W-1:0];
          state <= S_M6;
        end
        S_M6: begin
          acc   <= acc + {mul_p[PROD_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}};
          state <= S_CMP;
        end
        S_CMP: begin
          st_done   <= 1'b1;
          st_stable <= stable;
          if (stable) begin
            state <= S_DIV;
          end else begin
            reference_offset   <= last_sample;
            offset_valid       <= 1'b1;
            sample_total       <= '0;
            heading_sum        <= '0;
            heading_square_sum <= '0;
            state              <= S_WRITE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            reference_offset   <= div_q[HEAD_W-1:0];
            offset_valid       <= 1'b1;
            sample_total       <= '0;
            heading_sum        <= '0;
            heading_square_sum <= '0;
            state              <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (!result.valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HRO_ASSERT_NEXT(a_one_item, sample.valid && sample.ready, !sample.ready,
                   "item overlap")
  `HRO_ASSERT_NOW(a_stable_done, result.valid && result.reference_stable,
                  result.reference_done, "stable without done")
  `HRO_ASSERT_NOW(a_done_applied, result.valid && result.reference_done,
                  result.offset_applied, "done without offset")
  `HRO_ASSERT_NOW(a_ref_zero, result.valid && result.reference_done,
                  result.heading_out == '0, "reference heading not zero")

endmodule

@@ tb/sv/heading_reference_offset_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for heading_reference_offset_unit: directed and random samples,
// checked against an in-bench predictor of the heading statistics and offset.
// Depends on hro_pkg, hro_channels and the unit itself.
module heading_reference_offset_unit_tb;
  import hro_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int IDLE_PERCENT  = 28;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic signed [OUT_W-1:0] heading_out;
    logic                    offset_applied;
    logic                    reference_done;
    logic                    reference_stable;
  } heading_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hro_sample_if sample_ch ();
  hro_result_if result_ch ();

  heading_reference_offset_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [CNT_W-1:0]  cfg_ref_length   = REF_LENGTH_RESET;
  logic [THR_W-1:0]  cfg_threshold    = STD_THRESHOLD_RESET;
  logic [CNT_W-1:0]  ref_count        = '0;
  logic [SUM_W-1:0]  ref_sum          = '0;
  logic [SQS_W-1:0]  ref_square_sum   = '0;
  logic [HEAD_W-1:0] ref_last         = '0;
  logic [HEAD_W-1:0] ref_offset       = '0;
  logic              offset_on        = 1'b0;

  heading_result_t expected_headings[$];

  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int stable_refs     = 0;
  int unstable_refs   = 0;
  int cycle_count     = 0;
  int hold_request    = 0;
  bit steady          = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycle_count,
               expected_headings.size());
      $display("heading_reference_offset_unit_tb: errors");
      $finish;
    end
  end

  function automatic heading_result_t predict_heading(input logic kind,
                                                      input logic [HEAD_W-1:0] raw);
    logic [HEAD_W-1:0] h;
    int                target;
    longint unsigned   n;
    longint unsigned   spread;
    longint unsigned   lim;
    int                d;
    heading_result_t   r;
    h = (raw >= TURN) ? raw - TURN : raw;
    r = '0;
    if (kind == CMD_REFERENCE) begin
      ref_count      = ref_count + 1'b1;
      ref_sum        = ref_sum + SUM_W'(h);
      ref_square_sum = ref_square_sum + SQS_W'(h) * SQS_W'(h);
      ref_last       = h;
      target = (cfg_ref_length == 0) ? 1 : int'(cfg_ref_length);
      if (target > MAX_SAMPLES) target = MAX_SAMPLES;
      if (int'(ref_count) >= target) begin
        n      = longint'(ref_count);
        spread = n * longint'(ref_square_sum) - longint'(ref_sum) * longint'(ref_sum);
        lim    = longint'(cfg_threshold) * n;
        r.reference_done = 1'b1;
        if (spread < lim * lim) begin
          r.reference_stable = 1'b1;
          ref_offset = HEAD_W'((longint'(ref_sum) + n / 2) / n);
          stable_refs++;
        end else begin
          ref_offset = ref_last;
          unstable_refs++;
        end
        offset_on      = 1'b1;
        ref_count      = '0;
        ref_sum        = '0;
        ref_square_sum = '0;
      end
    end else if (offset_on) begin
      d = int'(h) - int'(ref_offset);
      if (d > int'(HALF_TURN)) d -= int'(TURN);
      if (d < -int'(HALF_TURN)) d += int'(TURN);
      r.heading_out = OUT_W'(d);
    end else begin
      r.heading_out = OUT_W'(h);
    end
    r.offset_applied = offset_on;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  initial begin : drive_result_ready
    int hold_left;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    heading_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_headings.size() == 0) begin
        report_mismatch("result with nothing expected", int'(result_ch.heading_out), 0);
      end else begin
        want = expected_headings.pop_front();
        results_checked++;
        if (result_ch.heading_out !== want.heading_out)
          report_mismatch("heading_out", int'(result_ch.heading_out),
                          int'($signed(want.heading_out)));
        if (result_ch.offset_applied !== want.offset_applied)
          report_mismatch("offset_applied", int'(result_ch.offset_applied),
                          int'(want.offset_applied));
        if (result_ch.reference_done !== want.reference_done)
          report_mismatch("reference_done", int'(result_ch.reference_done),
                          int'(want.reference_done));
        if (result_ch.reference_stable !== want.reference_stable)
          report_mismatch("reference_stable", int'(result_ch.reference_stable),
                          int'(want.reference_stable));
      end
    end
  end

  task automatic send_sample(input logic kind, input logic [HEAD_W-1:0] raw);
    int gap;
    gap = (!steady && $urandom_range(99) < IDLE_PERCENT) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
    end
    @(negedge clk);
    sample_ch.valid   <= 1'b1;
    sample_ch.cmd     <= kind;
    sample_ch.heading <= raw;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    expected_headings.push_back(predict_heading(kind, raw));
    items_sent++;
  endtask

  // hold valid low until every expected transfer has come back
  task automatic wait_drained();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_headings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_REF_LENGTH:    cfg_ref_length = value[CNT_W-1:0];
      REG_STD_THRESHOLD: cfg_threshold  = value[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int count, input int thr);
    wait_drained();
    write_reg(REG_REF_LENGTH, CFG_DATA_W'(count));
    write_reg(REG_STD_THRESHOLD, CFG_DATA_W'(thr));
  endtask

  // pick a heading around centre, wrapped, sometimes in its unfolded form
  function automatic logic [HEAD_W-1:0] near_heading(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    v = ((v % int'(TURN)) + int'(TURN)) % int'(TURN);
    if (v < 8192 - int'(TURN) && $urandom_range(7) == 0) v += int'(TURN);
    return HEAD_W'(v);
  endfunction

  task automatic run_random_phase(input int items, input int count, input int thr);
    int sent;
    int target;
    int centre;
    int spread;
    int pick;
    int burst;
    configure(count, thr);
    target = (count == 0) ? 1 : count;
    sent = 0;
    while (sent < items) begin
      pick   = $urandom_range(99);
      centre = $urandom_range(int'(TURN) - 1);
      spread = ($urandom_range(3) == 0) ? $urandom_range(2880) : $urandom_range(2 * thr + 2);
      if (spread > 2880) spread = 2880;
      if (pick < 85) begin
        burst = (pick < 75) ? target : $urandom_range(1, target);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(3) == 0) begin
            send_sample(CMD_MEASURE, HEAD_W'($urandom_range(8191)));
            sent++;
          end
          send_sample(CMD_REFERENCE, near_heading(centre, spread));
          sent++;
        end
        for (int k = $urandom_range(1, 3); k > 0; k--) begin
          send_sample(CMD_MEASURE, HEAD_W'($urandom_range(8191)));
          sent++;
        end
      end else begin
        send_sample(1'($urandom_range(1)), HEAD_W'($urandom_range(8191)));
        sent++;
      end
    end
  endtask

  task automatic test_passthrough();
    send_sample(CMD_MEASURE, HEAD_W'(0));
    send_sample(CMD_MEASURE, HEAD_W'(5759));
    send_sample(CMD_MEASURE, HEAD_W'(5760));
    send_sample(CMD_MEASURE, HEAD_W'(8191));
    send_sample(CMD_REFERENCE, HEAD_W'(100));
  endtask

  task automatic test_offset_wrap();
    configure(0, 0);
    send_sample(CMD_REFERENCE, HEAD_W'(8191));
    send_sample(CMD_MEASURE, HEAD_W'(2431));
    send_sample(CMD_MEASURE, HEAD_W'(5311));
    send_sample(CMD_MEASURE, HEAD_W'(5312));
    configure(1, 8191);
    send_sample(CMD_REFERENCE, HEAD_W'(0));
    send_sample(CMD_MEASURE, HEAD_W'(2880));
    send_sample(CMD_MEASURE, HEAD_W'(2881));
    send_sample(CMD_REFERENCE, HEAD_W'(5759));
    send_sample(CMD_MEASURE, HEAD_W'(2879));
    send_sample(CMD_MEASURE, HEAD_W'(2878));
    send_sample(CMD_MEASURE, HEAD_W'(0));
    configure(2, 1);
    send_sample(CMD_REFERENCE, HEAD_W'(1000));
    send_sample(CMD_REFERENCE, HEAD_W'(1001));
    send_sample(CMD_MEASURE, HEAD_W'(1001));
    send_sample(CMD_REFERENCE, HEAD_W'(0));
    send_sample(CMD_REFERENCE, HEAD_W'(5759));
    send_sample(CMD_MEASURE, HEAD_W'(5759));
    wait_drained();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '0);
    write_reg(REG_REF_LENGTH, CFG_DATA_W'(13'h1C02));
    send_sample(CMD_REFERENCE, HEAD_W'(4000));
    send_sample(CMD_REFERENCE, HEAD_W'(4002));
    send_sample(CMD_MEASURE, HEAD_W'(4002));
  endtask

  task automatic test_target_lowered();
    int centre;
    configure(MAX_SAMPLES, 5760);
    centre = $urandom_range(int'(TURN) - 1);
    repeat (150) send_sample(CMD_REFERENCE, near_heading(centre, 1500));
    configure(20, 5760);
    send_sample(CMD_REFERENCE, near_heading(centre, 1500));
    repeat (3) send_sample(CMD_MEASURE, HEAD_W'($urandom_range(8191)));
  endtask

  task automatic test_output_stall();
    int centre;
    configure(3, 40);
    centre = $urandom_range(int'(TURN) - 1);
    hold_request = 150;
    repeat (40) send_sample(1'($urandom_range(1)), near_heading(centre, 60));
    wait_drained();
    repeat (20) send_sample(1'($urandom_range(1)), near_heading(centre, 60));
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    run_random_phase(100, 4, 24);
    steady = 1'b0;
  endtask

  task automatic test_random_mix();
    int counts[11]     = '{1, 0, 3, 5, 8, 12, 2, 30, 4, 60, 7};
    int thresholds[11] = '{0, 8191, 16, 5760, -1, -1, 1, -1, -1, 40, -1};
    int thr;
    for (int p = 0; p < 11; p++) begin
      thr = (thresholds[p] < 0) ? $urandom_range(200) : thresholds[p];
      run_random_phase(56, counts[p], thr);
    end
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.cmd     <= CMD_REFERENCE;
    sample_ch.heading <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_passthrough();
    test_offset_wrap();
    test_target_lowered();
    test_output_stall();
    test_steady_stream();
    test_random_mix();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d samples over several count and threshold settings, %0d checked",
             items_sent, results_checked);
    $display("references completed: %0d stable, %0d unstable", stable_refs, unstable_refs);
    if (mismatch_count == 0) begin
      $display("heading_reference_offset_unit_tb: clean");
    end else begin
      $display("heading_reference_offset_unit_tb: errors");
    end
    $finish;
  end

endmodule
